// File: rtl/rle_sprite_row_decoder_macros.svh
// assertion macros for the run-length sprite row decoder
// included by modules that carry concurrent checks; needs nothing else
`ifndef RLE_SPRITE_ROW_DECODER_MACROS_SVH
`define RLE_SPRITE_ROW_DECODER_MACROS_SVH

// condition must hold at every clock edge out of reset
`define RSRD_ASSERT_HOLDS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("rsrd check failed");

// consequent must hold in the same cycle as the antecedent
`define RSRD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rsrd check failed");

// consequent must hold in the cycle after the antecedent
`define RSRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rsrd check failed");

`endif

// File: rtl/rsrd_pkg.sv
// shared widths, register indexes, status codes and result type
// for the run-length sprite row decoder; no dependencies
package rsrd_pkg;

	localparam int DATA_W     = 8;
	localparam int ROW_W      = 13;
	localparam int COL_OUT_W  = 13;
	localparam int LEN_W      = 7;
	localparam int COLOR_W    = 8;
	localparam int STATUS_W   = 2;
	localparam int CFG_W      = 14;
	localparam int CFG_IDX_W  = 2;
	localparam int ROW_CNT_W  = 14;
	localparam int RUN_W      = 7;

	localparam int ROW_LIMIT       = 8192;
	localparam int DEFAULT_MAX_DIM = 8192;

	localparam logic [CFG_IDX_W-1:0] REG_SHAPE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHAPE_HEIGHT = 2'd1;

	localparam logic [STATUS_W-1:0] ST_RUN   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_TRUNC = 2'd2;

	typedef struct packed {
		logic [ROW_W-1:0]     row_index;
		logic [COL_OUT_W-1:0] start_column;
		logic [LEN_W-1:0]     span_length;
		logic [COLOR_W-1:0]   pixel_color;
		logic [STATUS_W-1:0]  status;
	} span_t;

endpackage

// File: rtl/rsrd_ifs.sv
// valid/ready channel interfaces of the sprite row decoder:
// byte input, span output and register write port; uses rsrd_pkg
interface rsrd_byte_if;
	logic                          valid;
	logic                          ready;
	logic [rsrd_pkg::DATA_W-1:0]   data_byte;
	logic                          final_byte;

	modport source (output valid, data_byte, final_byte, input ready);
	modport sink   (input valid, data_byte, final_byte, output ready);
endinterface

interface rsrd_span_if;
	logic                            valid;
	logic                            ready;
	logic [rsrd_pkg::ROW_W-1:0]      row_index;
	logic [rsrd_pkg::COL_OUT_W-1:0]  start_column;
	logic [rsrd_pkg::LEN_W-1:0]      span_length;
	logic [rsrd_pkg::COLOR_W-1:0]    pixel_color;
	logic [rsrd_pkg::STATUS_W-1:0]   status;

	modport source (output valid, row_index, start_column, span_length, pixel_color, status,
		input ready);
	modport sink   (input valid, row_index, start_column, span_length, pixel_color, status,
		output ready);
endinterface

interface rsrd_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [rsrd_pkg::CFG_IDX_W-1:0]   index;
	logic [rsrd_pkg::CFG_W-1:0]       wdata;

	modport source (output valid, index, wdata, input ready);
	modport sink   (input valid, index, wdata, output ready);
endinterface

// File: rtl/rle_sprite_row_decoder.sv
// Run-length sprite row decoder.
// byte_stream carries one word per stream byte (data_byte, final_byte); span_stream
// carries one word per clipped span or status (row_index, start_column, span_length,
// pixel_color, status); cfg writes shape_width (index 0) and shape_height (index 1),
// is always ready and should only be written while the decoder is idle.
// Each accepted byte lands in an input register, is decoded combinationally against
// the row/column/run counters, and any result lands in the output register: a
// result reaches span_stream through the input register and then the output register.
// Throughput is one byte per clock while span_stream is ready; the single decode stage
// (one column add with saturation and one clip compare) sets that figure.
// A byte that produces nothing still passes through the decode stage, and a status word
// with no span carries zeros in row, column and color.
// Reset clears the counters, returns to the expect-control-byte phase and sets both
// shape registers to 1. When span_stream stalls, the output register holds its word,
// the input register takes one more byte if it is empty and then byte_stream ready drops.
// After a done or truncated status, further bytes are taken and dropped until reset.
// Depends on rsrd_pkg, rsrd_ifs and rle_sprite_row_decoder_macros.svh.
`include "rle_sprite_row_decoder_macros.svh"

module rle_sprite_row_decoder #(
	parameter int MAX_DIM = rsrd_pkg::DEFAULT_MAX_DIM
) (
	input logic           clk,
	input logic           arst_n,
	rsrd_byte_if.sink     byte_stream,
	rsrd_span_if.source   span_stream,
	rsrd_cfg_if.sink      cfg
);

	localparam int COL_W = $clog2(MAX_DIM + 1);
	localparam int SUM_W = ((COL_W > rsrd_pkg::DATA_W) ? COL_W : rsrd_pkg::DATA_W) + 1;
	localparam int CMP_W = (COL_W > rsrd_pkg::CFG_W) ? COL_W : rsrd_pkg::CFG_W;
	localparam logic [COL_W-1:0] COL_MAX = COL_W'(MAX_DIM);
	localparam logic [rsrd_pkg::CFG_W-1:0] CLIP_CAP = (MAX_DIM < rsrd_pkg::ROW_LIMIT) ?
		rsrd_pkg::CFG_W'(MAX_DIM) : rsrd_pkg::CFG_W'(rsrd_pkg::ROW_LIMIT);
	localparam logic [rsrd_pkg::CFG_W-1:0] HEIGHT_CAP = rsrd_pkg::CFG_W'(rsrd_pkg::ROW_LIMIT);

	localparam logic [2:0] PH_CTRL  = 3'd0;
	localparam logic [2:0] PH_SKIP  = 3'd1;
	localparam logic [2:0] PH_SOLID = 3'd2;
	localparam logic [2:0] PH_LIT   = 3'd3;
	localparam logic [2:0] PH_DONE  = 3'd4;
	localparam logic [2:0] PH_ERR   = 3'd5;

	logic [rsrd_pkg::CFG_W-1:0]     width_q;
	logic [rsrd_pkg::CFG_W-1:0]     height_q;
	logic [2:0]                     phase_q;
	logic [rsrd_pkg::ROW_CNT_W-1:0] row_q;
	logic [COL_W-1:0]               col_q;
	logic [rsrd_pkg::RUN_W-1:0]     run_q;

	logic                          valid_s1;
	logic [rsrd_pkg::DATA_W-1:0]   data_s1;
	logic                          final_s1;
	logic                          valid_s2;
	rsrd_pkg::span_t               result_s2;

	logic                          fire_s1;
	logic [2:0]                    phase_d;
	logic [rsrd_pkg::ROW_CNT_W-1:0] row_d;
	logic [COL_W-1:0]              col_d;
	logic [rsrd_pkg::RUN_W-1:0]    run_d;
	logic                          emit;
	rsrd_pkg::span_t               result_d;

	logic [rsrd_pkg::CFG_W-1:0]     lim;
	logic [rsrd_pkg::CFG_W-1:0]     rows_needed;
	logic [rsrd_pkg::DATA_W-1:0]    adv_n;
	logic [SUM_W-1:0]               col_sum;
	logic [COL_W-1:0]               col_adv;
	logic [CMP_W-1:0]               room_full;
	logic [rsrd_pkg::CFG_W-1:0]     room;
	logic                           in_clip;
	logic [rsrd_pkg::LEN_W-1:0]     solid_len;
	logic [rsrd_pkg::RUN_W-1:0]     ctrl_count;
	logic                           ctrl_lit;
	logic                           active;

	// handshakes
	assign fire_s1           = valid_s1 && (!valid_s2 || span_stream.ready);
	assign byte_stream.ready = !valid_s1 || fire_s1;
	assign cfg.ready         = 1'b1;

	assign span_stream.valid        = valid_s2;
	assign span_stream.row_index    = result_s2.row_index;
	assign span_stream.start_column = result_s2.start_column;
	assign span_stream.span_length  = result_s2.span_length;
	assign span_stream.pixel_color  = result_s2.pixel_color;
	assign span_stream.status       = result_s2.status;

	// clip limit and row count from the shape registers
	assign lim = (width_q < CLIP_CAP) ? width_q : CLIP_CAP;
	always_comb begin
		priority if (height_q == '0) begin
			rows_needed = rsrd_pkg::CFG_W'(1);
		end else if (height_q > HEIGHT_CAP) begin
			rows_needed = HEIGHT_CAP;
		end else begin
			rows_needed = height_q;
		end
	end

	// one shared column adder with saturation
	always_comb begin
		priority if (phase_q == PH_SKIP) begin
			adv_n = data_s1;
		end else if (phase_q == PH_SOLID) begin
			adv_n = rsrd_pkg::DATA_W'(run_q);
		end else begin
			adv_n = rsrd_pkg::DATA_W'(1);
		end
	end
	assign col_sum = SUM_W'(col_q) + SUM_W'(adv_n);
	assign col_adv = (col_sum > SUM_W'(MAX_DIM)) ? COL_MAX : col_sum[COL_W-1:0];

	assign in_clip   = CMP_W'(col_q) < CMP_W'(lim);
	assign room_full = CMP_W'(lim) - CMP_W'(col_q);
	assign room      = room_full[rsrd_pkg::CFG_W-1:0];
	assign solid_len = (rsrd_pkg::CFG_W'(run_q) < room) ? run_q : room[rsrd_pkg::LEN_W-1:0];

	assign ctrl_count = data_s1[rsrd_pkg::DATA_W-1:1];
	assign ctrl_lit   = data_s1[0];
	assign active     = (phase_q != PH_DONE) && (phase_q != PH_ERR);

	always_comb begin
		phase_d  = phase_q;
		row_d    = row_q;
		col_d    = col_q;
		run_d    = run_q;
		emit     = 1'b0;
		result_d = '0;
		unique case (phase_q)
			PH_CTRL: begin
				if (ctrl_count == '0 && !ctrl_lit) begin
					row_d = row_q + 1'b1;
					col_d = '0;
					if (row_d >= rows_needed) begin
						phase_d         = PH_DONE;
						emit            = 1'b1;
						result_d.status = rsrd_pkg::ST_DONE;
					end
				end else if (ctrl_count == '0) begin
					phase_d = PH_SKIP;
				end else begin
					run_d   = ctrl_count;
					phase_d = ctrl_lit ? PH_LIT : PH_SOLID;
				end
			end
			PH_SKIP: begin
				col_d   = col_adv;
				phase_d = PH_CTRL;
			end
			PH_SOLID: begin
				if (in_clip) begin
					emit                  = 1'b1;
					result_d.row_index    = row_q[rsrd_pkg::ROW_W-1:0];
					result_d.start_column = rsrd_pkg::COL_OUT_W'(col_q);
					result_d.span_length  = solid_len;
					result_d.pixel_color  = data_s1;
				end
				col_d   = col_adv;
				run_d   = '0;
				phase_d = PH_CTRL;
			end
			PH_LIT: begin
				if (in_clip) begin
					emit                  = 1'b1;
					result_d.row_index    = row_q[rsrd_pkg::ROW_W-1:0];
					result_d.start_column = rsrd_pkg::COL_OUT_W'(col_q);
					result_d.span_length  = rsrd_pkg::LEN_W'(1);
					result_d.pixel_color  = data_s1;
				end
				col_d = col_adv;
				if (run_q != '0) begin
					run_d = run_q - 1'b1;
				end
				if (run_d == '0) begin
					phase_d = PH_CTRL;
				end
			end
			default: begin
			end
		endcase
		// stream ran out before the shape finished
		if (active && final_s1 && phase_d != PH_DONE) begin
			phase_d         = PH_ERR;
			emit            = 1'b1;
			result_d.status = rsrd_pkg::ST_TRUNC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= rsrd_pkg::CFG_W'(1);
			height_q <= rsrd_pkg::CFG_W'(1);
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.index == rsrd_pkg::REG_SHAPE_WIDTH) begin
				width_q <= cfg.wdata;
			end
			if (cfg.index == rsrd_pkg::REG_SHAPE_HEIGHT) begin
				height_q <= cfg.wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CTRL;
			row_q   <= '0;
			col_q   <= '0;
			run_q   <= '0;
		end else if (fire_s1) begin
			phase_q <= phase_d;
			row_q   <= row_d;
			col_q   <= col_d;
			run_q   <= run_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_stream.ready) begin
			valid_s1 <= byte_stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_stream.valid && byte_stream.ready) begin
			data_s1  <= byte_stream.data_byte;
			final_s1 <= byte_stream.final_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire_s1) begin
			valid_s2 <= emit;
		end else if (span_stream.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			result_s2 <= result_d;
		end
	end

	`RSRD_ASSERT_IMPLIES(a_running_word_has_span, clk, arst_n,
		valid_s2 && result_s2.status == rsrd_pkg::ST_RUN, result_s2.span_length != '0)
	`RSRD_ASSERT_IMPLIES(a_status_word_clean, clk, arst_n,
		valid_s2 && result_s2.span_length == '0,
		result_s2.row_index == '0 && result_s2.start_column == '0 && result_s2.pixel_color == '0)
	`RSRD_ASSERT_NEXT(a_truncated_sticky, clk, arst_n, phase_q == PH_ERR, phase_q == PH_ERR)
	`RSRD_ASSERT_IMPLIES(a_no_run_outside_runs, clk, arst_n,
		phase_q == PH_CTRL || phase_q == PH_SKIP, run_q == '0)
	`RSRD_ASSERT_HOLDS(a_column_saturates, clk, arst_n, col_q <= COL_MAX)

endmodule
